>>> rtl/handheld_memory_map_bus_macros.svh
// Assertion helpers shared by the bus RTL.
`ifndef HANDHELD_MEMORY_MAP_BUS_MACROS_SVH
`define HANDHELD_MEMORY_MAP_BUS_MACROS_SVH

// Check prop in the same cycle as cond.
`define HMMB_ASSERT_IMPL(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("hmmb check failed");

// Check prop in the cycle after cond.
`define HMMB_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("hmmb check failed");

`endif

>>> rtl/hmmb_pkg.sv
package hmmb_pkg;

  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned MEM_DEPTH   = 65536;
  localparam int unsigned DMA_LENGTH  = 160;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] ACT_READ_BYTE = 2'd0;
  localparam logic [1:0] ACT_READ_WORD = 2'd1;
  localparam logic [1:0] ACT_WRITE     = 2'd2;
  localparam logic [1:0] ACT_LOAD      = 2'd3;

  localparam logic [ADDR_W-1:0] ROM_END        = 16'h8000;
  localparam logic [ADDR_W-1:0] ECHO_START     = 16'hE000;
  localparam logic [ADDR_W-1:0] ECHO_END       = 16'hFE00;
  localparam logic [ADDR_W-1:0] ECHO_OFFSET    = 16'h2000;
  localparam logic [ADDR_W-1:0] OAM_START      = 16'hFE00;
  localparam logic [ADDR_W-1:0] RESTRICT_START = 16'hFEA0;
  localparam logic [ADDR_W-1:0] RESTRICT_END   = 16'hFEFF;
  localparam logic [ADDR_W-1:0] REG_DIV        = 16'hFF04;
  localparam logic [ADDR_W-1:0] REG_LY         = 16'hFF44;
  localparam logic [ADDR_W-1:0] REG_DMA        = 16'hFF46;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_value;
  } request_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_value;
    logic              refused;
  } response_t;

  typedef enum logic [2:0] {
    OP_READ_BYTE,
    OP_READ_WORD,
    OP_STORE,
    OP_ECHO,
    OP_REFUSE,
    OP_DMA
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic in_restricted(input logic [ADDR_W-1:0] a);
    return (a >= RESTRICT_START) && (a < RESTRICT_END);
  endfunction

endpackage

>>> rtl/handheld_memory_map_bus.sv
// A store, load or refused write is done from the idle state; a byte read passes S_RD_LO,
// a word read S_RD_LO and S_RD_HI, an echo write S_ECHO, a DMA DMA_LENGTH pairs of
// S_DMA_RD and S_DMA_WR. One store per cycle once clearing ends; a read, echo or DMA holds
// the single read and write port of the 64 KiB memory until it is done, stalling the next.
// Reset: a clearing pass writes zero over all 65536 bytes, one per cycle, with busy high.
// Results are strobed for one cycle with done; the receiver cannot stall.
module handheld_memory_map_bus #(
  parameter int unsigned DMA_LENGTH = hmmb_pkg::DMA_LENGTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  hmmb_pkg::request_t  request,
  output logic                busy,
  output logic                done,
  output hmmb_pkg::response_t response
);

  hmmb_pkg::queue_entry_t  front_entry;
  hmmb_pkg::queue_entry_t  head;
  hmmb_pkg::queue_status_t q_status;
  logic                    push;
  logic                    pop;
  logic                    clearing;

  assign busy = clearing || q_status.full;
  assign push = start && !busy;

  hmmb_front u_front (
    .request (request),
    .entry   (front_entry)
  );

  hmmb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (front_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  hmmb_back #(
    .DMA_LENGTH (DMA_LENGTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .clearing (clearing),
    .done     (done),
    .response (response)
  );

endmodule

>>> rtl/hmmb_front.sv
module hmmb_front (
  input  hmmb_pkg::request_t     request,
  output hmmb_pkg::queue_entry_t entry
);

  always_comb begin
    entry.address = request.address;
    entry.data    = request.write_value;
    entry.kind    = hmmb_pkg::OP_STORE;
    unique case (request.action)
      hmmb_pkg::ACT_READ_BYTE: entry.kind = hmmb_pkg::OP_READ_BYTE;
      hmmb_pkg::ACT_READ_WORD: entry.kind = hmmb_pkg::OP_READ_WORD;
      hmmb_pkg::ACT_LOAD:      entry.kind = hmmb_pkg::OP_STORE;
      hmmb_pkg::ACT_WRITE: begin
        if (request.address == hmmb_pkg::REG_DMA) begin
          entry.kind = hmmb_pkg::OP_DMA;
        end else if (request.address < hmmb_pkg::ROM_END) begin
          entry.kind = hmmb_pkg::OP_REFUSE;
        end else if (request.address >= hmmb_pkg::ECHO_START &&
                     request.address < hmmb_pkg::ECHO_END) begin
          entry.kind = hmmb_pkg::OP_ECHO;
        end else if (hmmb_pkg::in_restricted(request.address)) begin
          entry.kind = hmmb_pkg::OP_REFUSE;
        end else if (request.address == hmmb_pkg::REG_DIV ||
                     request.address == hmmb_pkg::REG_LY) begin
          // Counter registers clear on any write.
          entry.data = '0;
        end
      end
      default: entry.kind = hmmb_pkg::OP_STORE;
    endcase
  end

endmodule

>>> rtl/hmmb_queue.sv
`include "handheld_memory_map_bus_macros.svh"

module hmmb_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  hmmb_pkg::queue_entry_t  push_entry,
  input  logic                    pop,
  output hmmb_pkg::queue_entry_t  head,
  output hmmb_pkg::queue_status_t status
);

  localparam int unsigned DEPTH = hmmb_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hmmb_pkg::queue_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  `HMMB_ASSERT_IMPL(a_pop_not_empty, clk, rst, pop, count != '0)
  `HMMB_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))

endmodule

>>> rtl/hmmb_back.sv
`include "handheld_memory_map_bus_macros.svh"

module hmmb_back #(
  parameter int unsigned DMA_LENGTH = hmmb_pkg::DMA_LENGTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  hmmb_pkg::queue_entry_t  head,
  input  hmmb_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    clearing,
  output logic                    done,
  output hmmb_pkg::response_t     response
);

  localparam int unsigned AW    = hmmb_pkg::ADDR_W;
  localparam int unsigned DW    = hmmb_pkg::DATA_W;
  localparam int unsigned IDX_W = (DMA_LENGTH > 1) ? $clog2(DMA_LENGTH) : 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_LO,
    S_RD_HI,
    S_ECHO,
    S_DMA_RD,
    S_DMA_WR
  } state_t;

  state_t           state;
  logic [AW-1:0]    clear_addr;
  logic [AW-1:0]    cur_addr;
  logic [DW-1:0]    cur_data;
  logic             is_word;
  logic [DW-1:0]    low_byte;
  logic [IDX_W-1:0] dma_idx;

  logic [DW-1:0] mem [hmmb_pkg::MEM_DEPTH];
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic          we;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  always_comb begin
    pop     = 1'b0;
    rd_addr = cur_addr;
    we      = 1'b0;
    wr_addr = cur_addr;
    wr_data = cur_data;
    case (state)
      S_CLEAR: begin
        we      = 1'b1;
        wr_addr = clear_addr;
        wr_data = '0;
      end
      S_IDLE: begin
        pop     = !q_status.empty;
        rd_addr = head.address;
        wr_addr = head.address;
        wr_data = head.data;
        we      = pop && (head.kind == hmmb_pkg::OP_STORE ||
                          head.kind == hmmb_pkg::OP_ECHO);
      end
      S_RD_LO: rd_addr = cur_addr + AW'(1);
      S_ECHO: begin
        we      = 1'b1;
        wr_addr = cur_addr - hmmb_pkg::ECHO_OFFSET;
      end
      S_DMA_RD: rd_addr = {cur_data, {(AW-DW){1'b0}}} + AW'(dma_idx);
      S_DMA_WR: begin
        wr_addr = hmmb_pkg::OAM_START + AW'(dma_idx);
        wr_data = rd_data;
        // Drop copied bytes that land in the restricted window.
        we      = !hmmb_pkg::in_restricted(wr_addr);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_addr <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + AW'(1);
          if (clear_addr == AW'(hmmb_pkg::MEM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            cur_addr <= head.address;
            cur_data <= head.data;
            unique case (head.kind)
              hmmb_pkg::OP_READ_BYTE: begin
                is_word <= 1'b0;
                state   <= S_RD_LO;
              end
              hmmb_pkg::OP_READ_WORD: begin
                is_word <= 1'b1;
                state   <= S_RD_LO;
              end
              hmmb_pkg::OP_STORE: begin
                done     <= 1'b1;
                response <= '0;
              end
              hmmb_pkg::OP_ECHO: state <= S_ECHO;
              hmmb_pkg::OP_REFUSE: begin
                done                <= 1'b1;
                response.read_value <= '0;
                response.refused    <= 1'b1;
              end
              hmmb_pkg::OP_DMA: begin
                dma_idx <= '0;
                state   <= S_DMA_RD;
              end
              default: ;
            endcase
          end
        end
        S_RD_LO: begin
          if (is_word) begin
            low_byte <= rd_data;
            state    <= S_RD_HI;
          end else begin
            done                <= 1'b1;
            response.read_value <= {{DW{1'b0}}, rd_data};
            response.refused    <= 1'b0;
            state               <= S_IDLE;
          end
        end
        S_RD_HI: begin
          done                <= 1'b1;
          response.read_value <= {rd_data, low_byte};
          response.refused    <= 1'b0;
          state               <= S_IDLE;
        end
        S_ECHO: begin
          done     <= 1'b1;
          response <= '0;
          state    <= S_IDLE;
        end
        S_DMA_RD: state <= S_DMA_WR;
        S_DMA_WR: begin
          if (dma_idx == IDX_W'(DMA_LENGTH - 1)) begin
            done     <= 1'b1;
            response <= '0;
            state    <= S_IDLE;
          end else begin
            dma_idx <= dma_idx + IDX_W'(1);
            state   <= S_DMA_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign clearing = (state == S_CLEAR);

  `HMMB_ASSERT_IMPL(a_no_done_clear, clk, rst, state == S_CLEAR, !done)
  `HMMB_ASSERT_IMPL(a_dma_pairs, clk, rst, state == S_DMA_WR, $past(state) == S_DMA_RD)
  `HMMB_ASSERT_NEXT(a_word_done, clk, rst, state == S_RD_HI, done)
  `HMMB_ASSERT_IMPL(a_echo_from_idle, clk, rst, state == S_ECHO, $past(state) == S_IDLE)

endmodule
